// ----- sv/pedd_pkg.sv -----
// ----------------------------------------------------------------------------
// pedd_pkg: shared definitions of the palette error diffusion ditherer
// Sizes, codes, the controller state type, the command bundle and the
// rounding helper used by the datapath.
// ----------------------------------------------------------------------------
package pedd_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int PAL_DEPTH   = 16;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int MEM_AW      = COL_W + 1;
    localparam int WCFG_W      = 11;
    localparam int HCFG_W      = 13;
    localparam int NCFG_W      = 5;
    localparam int CFG_DATA_W  = 13;
    localparam int PAL_IDX_W   = 4;

    localparam logic [1:0] OP_PALETTE  = 2'd0;
    localparam logic [1:0] OP_PIXEL    = 2'd1;
    localparam logic [1:0] OP_DRAIN    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STORE,
        ST_FETCH_X,
        ST_FETCH_R,
        ST_FETCH_L,
        ST_CAPT,
        ST_SEARCH,
        ST_WRITE_R,
        ST_WRITE_L,
        ST_WRITE_C,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        WSRC_V,
        WSRC_R7,
        WSRC_L3,
        WSRC_C5
    } wsrc_t;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_X,
        CAP_R,
        CAP_L
    } cap_t;

    typedef struct packed {
        logic                 pal_we;
        logic                 v_load;
        logic                 v_spread;
        logic                 held_clear;
        logic                 held_load;
        logic [MEM_AW-1:0]    mem_addr;
        logic                 mem_we;
        wsrc_t                wsrc;
        cap_t                 cap;
        logic                 search_init;
        logic                 search_step;
        logic [PAL_IDX_W-1:0] pal_idx;
        logic                 out_load;
        logic                 out_eoi;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    // px + err*k/16, rounded half to even, clamped to 0..255.
    function automatic logic [7:0] spread_ch(logic [7:0] px, logic signed [8:0] err,
                                             logic [2:0] k);
        logic signed [15:0] t;
        logic [9:0]         q;
        logic [3:0]         rem;
        logic [10:0]        qr;
        t   = $signed({4'd0, px, 4'd0}) + 16'(err) * $signed({13'd0, k})
              + 16'sd4096;
        q   = t[13:4];
        rem = t[3:0];
        qr  = {1'b0, q} + (((rem > 4'd8) || ((rem == 4'd8) && q[0])) ? 11'd1 : 11'd0);
        if (qr < 11'd256) begin
            spread_ch = 8'd0;
        end else if (qr > 11'd511) begin
            spread_ch = 8'd255;
        end else begin
            spread_ch = qr[7:0];
        end
    endfunction

endpackage

// ----- sv/palette_error_diffusion_dither.sv -----
// ----------------------------------------------------------------------------
// palette_error_diffusion_dither: Floyd-Steinberg dithering to a palette
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order and leave one row later as the nearest entry
// of a loaded palette of up to 16 colors, with the quantization error spread
// by the 7/3/5/1 sixteenths weights. Load the palette with palette write
// requests first, then send width*height pixel requests, then width drain
// requests to flush the last row; end_of_image marks the final result. A
// first-row pixel is only stored in a row buffer. Every other pixel or drain
// runs a nearest-color search that walks the palette one entry per cycle,
// its length set by palette_count, between single-port accesses to the row
// buffers. A result may wait in the output register while the next request
// is taken. The user must write configuration only while idle; the block
// itself does not enforce it. Writing the width or height restarts the image.
module palette_error_diffusion_dither
    import pedd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic [3:0]            palette_slot,
    input  logic [7:0]            chan0,
    input  logic [7:0]            chan1,
    input  logic [7:0]            chan2,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_chan0,
    output logic [7:0]            out_chan1,
    output logic [7:0]            out_chan2,
    output logic [3:0]            palette_choice,
    output logic                  end_of_image
);

    // Command and status bundles between the sequencer and the datapath.
    cmd_t    cmd;
    status_t status;

    pedd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd)
    );

    pedd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .palette_slot   (palette_slot),
        .chan0          (chan0),
        .chan1          (chan1),
        .chan2          (chan2),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_chan0      (out_chan0),
        .out_chan1      (out_chan1),
        .out_chan2      (out_chan2),
        .palette_choice (palette_choice),
        .end_of_image   (end_of_image)
    );

endmodule

// ----- sv/pedd_ctrl.sv -----
// ----------------------------------------------------------------------------
// pedd_ctrl: sequencer of the palette error diffusion ditherer
// Holds configuration, stream position and the state machine that steps the
// datapath through fetch, palette search and error write-back.
// ----------------------------------------------------------------------------
module pedd_ctrl
    import pedd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  status_t               status,
    output cmd_t                  cmd
);

    state_t             state_reg, state_next;
    logic [WCFG_W-1:0]  width_reg, width_next;
    logic [HCFG_W-1:0]  height_reg, height_next;
    logic [NCFG_W-1:0]  count_reg, count_next;
    logic [COL_W-1:0]   in_col_reg, in_col_next;
    logic [HCFG_W-1:0]  in_row_reg, in_row_next;
    logic [WCFG_W-1:0]  out_col_reg, out_col_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic               sel_reg, sel_next;
    logic               below_reg, below_next;
    logic               right_reg, right_next;
    logic               last_reg, last_next;
    logic               swap_reg, swap_next;
    logic [PAL_IDX_W-1:0] idx_reg, idx_next;

    logic [WCFG_W-1:0]  w_eff;
    logic [HCFG_W-1:0]  h_eff;
    logic [NCFG_W-1:0]  n_eff;
    logic               accept;
    logic               pix_ok;
    logic               drain_ok;
    logic               drain_last;
    logic               search_last;
    logic               restart_cfg;

    always_comb
    begin
        if (width_reg == '0) begin
            w_eff = WCFG_W'(1);
        end else if (width_reg > WCFG_W'(MAX_WIDTH)) begin
            w_eff = WCFG_W'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == '0) begin
            h_eff = HCFG_W'(1);
        end else if (height_reg > HCFG_W'(MAX_HEIGHT)) begin
            h_eff = HCFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
        if (count_reg == '0) begin
            n_eff = NCFG_W'(1);
        end else if (count_reg > NCFG_W'(PAL_DEPTH)) begin
            n_eff = NCFG_W'(PAL_DEPTH);
        end else begin
            n_eff = count_reg;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign pix_ok      = (in_row_reg < h_eff) && ({1'b0, in_col_reg} < w_eff);
    assign drain_ok    = (in_row_reg == h_eff) && (out_col_reg < w_eff);
    assign drain_last  = (out_col_reg + WCFG_W'(1)) >= w_eff;
    assign search_last = ({1'b0, idx_reg} + NCFG_W'(1)) == n_eff;
    assign restart_cfg = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == OP_PIXEL) && pix_ok) begin
                    state_next = (in_row_reg == '0) ? ST_STORE : ST_FETCH_X;
                end else if (accept && (operation == OP_DRAIN) && drain_ok) begin
                    state_next = ST_FETCH_X;
                end
            end
            ST_STORE:   state_next = ST_IDLE;
            ST_FETCH_X: state_next = ST_FETCH_R;
            ST_FETCH_R: state_next = ST_FETCH_L;
            ST_FETCH_L: state_next = ST_CAPT;
            ST_CAPT:    state_next = ST_SEARCH;
            ST_SEARCH:
            begin
                if (search_last) begin
                    state_next = ST_WRITE_R;
                end
            end
            ST_WRITE_R: state_next = ST_WRITE_L;
            ST_WRITE_L: state_next = ST_WRITE_C;
            ST_WRITE_C: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd          = '0;
        cmd.wsrc     = WSRC_V;
        cmd.cap      = CAP_NONE;
        cmd.mem_addr = {sel_reg, col_reg};
        cmd.pal_idx  = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.pal_we     = accept && (operation == OP_PALETTE);
                cmd.v_load     = accept && (operation == OP_PIXEL);
                cmd.v_spread   = (in_row_reg != '0) && (in_col_reg != '0);
                cmd.held_clear = (accept && (operation == OP_DRAIN) && drain_ok && drain_last)
                                 || restart_cfg;
            end
            ST_STORE:
            begin
                cmd.mem_we   = 1'b1;
                cmd.wsrc     = WSRC_V;
                cmd.mem_addr = {~sel_reg, col_reg};
            end
            ST_FETCH_X: cmd.mem_addr = {sel_reg, col_reg};
            ST_FETCH_R:
            begin
                cmd.mem_addr = {sel_reg, col_reg + COL_W'(1)};
                cmd.cap      = CAP_X;
            end
            ST_FETCH_L:
            begin
                cmd.mem_addr = {~sel_reg, col_reg - COL_W'(1)};
                cmd.cap      = CAP_R;
            end
            ST_CAPT:
            begin
                cmd.cap         = CAP_L;
                cmd.search_init = 1'b1;
            end
            ST_SEARCH:  cmd.search_step = 1'b1;
            ST_WRITE_R:
            begin
                cmd.mem_addr = {sel_reg, col_reg + COL_W'(1)};
                cmd.mem_we   = right_reg;
                cmd.wsrc     = WSRC_R7;
            end
            ST_WRITE_L:
            begin
                cmd.mem_addr = {~sel_reg, col_reg - COL_W'(1)};
                cmd.mem_we   = below_reg && (col_reg != '0);
                cmd.wsrc     = WSRC_L3;
            end
            ST_WRITE_C:
            begin
                cmd.mem_addr  = {~sel_reg, col_reg};
                cmd.mem_we    = below_reg;
                cmd.wsrc      = WSRC_C5;
                cmd.held_load = below_reg && right_reg;
            end
            ST_FINISH:
            begin
                cmd.out_load = !status.out_busy;
                cmd.out_eoi  = last_reg;
            end
            default:    cmd = '0;
        endcase
    end

    // Register updates.
    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        count_next   = count_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        col_next     = col_reg;
        sel_next     = sel_reg;
        below_next   = below_reg;
        right_next   = right_reg;
        last_next    = last_reg;
        swap_next    = swap_reg;
        idx_next     = idx_reg;
        if ((state_reg == ST_IDLE) && accept) begin
            if ((operation == OP_PIXEL) && pix_ok) begin
                col_next   = in_col_reg;
                below_next = 1'b1;
                right_next = ({1'b0, in_col_reg} + WCFG_W'(1)) < w_eff;
                last_next  = 1'b0;
                if (in_row_reg != '0) begin
                    out_col_next = {1'b0, in_col_reg} + WCFG_W'(1);
                end
                if (({1'b0, in_col_reg} + WCFG_W'(1)) >= w_eff) begin
                    in_col_next  = '0;
                    in_row_next  = in_row_reg + HCFG_W'(1);
                    out_col_next = '0;
                    swap_next    = 1'b1;
                end else begin
                    in_col_next = in_col_reg + COL_W'(1);
                    swap_next   = 1'b0;
                end
            end else if ((operation == OP_DRAIN) && drain_ok) begin
                col_next   = out_col_reg[COL_W-1:0];
                below_next = 1'b0;
                right_next = !drain_last;
                last_next  = drain_last;
                swap_next  = 1'b0;
                if (drain_last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                end else begin
                    out_col_next = out_col_reg + WCFG_W'(1);
                end
            end
        end
        if (cfg_we) begin
            case (cfg_index)
                REG_WIDTH:
                begin
                    width_next   = cfg_data[WCFG_W-1:0];
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                end
                REG_HEIGHT:
                begin
                    height_next  = cfg_data[HCFG_W-1:0];
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                end
                REG_COUNT: count_next = cfg_data[NCFG_W-1:0];
                default:   count_next = count_reg;
            endcase
        end
        if (state_reg == ST_CAPT) begin
            idx_next = '0;
        end else if (state_reg == ST_SEARCH) begin
            idx_next = idx_reg + PAL_IDX_W'(1);
        end
        if (((state_reg == ST_STORE) || ((state_reg == ST_FINISH) && !status.out_busy))
            && swap_reg) begin
            sel_next  = ~sel_reg;
            swap_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            width_reg   <= WCFG_W'(1);
            height_reg  <= HCFG_W'(1);
            count_reg   <= NCFG_W'(PAL_DEPTH);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            col_reg     <= '0;
            sel_reg     <= 1'b0;
            below_reg   <= 1'b0;
            right_reg   <= 1'b0;
            last_reg    <= 1'b0;
            swap_reg    <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            count_reg   <= count_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            col_reg     <= col_next;
            sel_reg     <= sel_next;
            below_reg   <= below_next;
            right_reg   <= right_next;
            last_reg    <= last_next;
            swap_reg    <= swap_next;
            idx_reg     <= idx_next;
        end
    end

endmodule

// ----- sv/pedd_datapath.sv -----
// ----------------------------------------------------------------------------
// pedd_datapath: storage and arithmetic of the palette error diffusion ditherer
// Palette, the two row buffers, the nearest colour search, the error
// spreading and the output register.
// ----------------------------------------------------------------------------
module pedd_datapath
    import pedd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic [PAL_IDX_W-1:0] palette_slot,
    input  logic [7:0]           chan0,
    input  logic [7:0]           chan1,
    input  logic [7:0]           chan2,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_chan0,
    output logic [7:0]           out_chan1,
    output logic [7:0]           out_chan2,
    output logic [3:0]           palette_choice,
    output logic                 end_of_image
);

    logic [23:0] pal_mem [PAL_DEPTH];
    logic [23:0] row_mem [2**MEM_AW];
    logic [23:0] rdata_reg;

    logic [23:0] x_reg, r_reg, l_reg, v_reg;
    logic [23:0] best_col_reg;
    logic [PAL_IDX_W-1:0] best_idx_reg;
    logic [17:0] best_d_reg;
    logic        first_reg;
    logic signed [8:0] held_reg [3];
    logic signed [8:0] err [3];

    logic        out_valid_reg;
    logic [23:0] out_col_reg;
    logic [3:0]  out_idx_reg;
    logic        out_eoi_reg;

    logic [23:0] chan_in;
    logic [23:0] v_in;
    logic [23:0] pal_rd;
    logic [23:0] wdata;
    logic [17:0] dist_sum;
    logic signed [8:0]  df [3];
    logic signed [17:0] sq [3];

    assign chan_in = {chan2, chan1, chan0};
    assign pal_rd  = pal_mem[cmd.pal_idx];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++) begin
            v_in[ch*8 +: 8] = cmd.v_spread
                ? spread_ch(chan_in[ch*8 +: 8], held_reg[ch], 3'd1)
                : chan_in[ch*8 +: 8];
            df[ch]  = $signed({1'b0, x_reg[ch*8 +: 8]}) - $signed({1'b0, pal_rd[ch*8 +: 8]});
            sq[ch]  = df[ch] * df[ch];
            err[ch] = $signed({1'b0, x_reg[ch*8 +: 8]})
                      - $signed({1'b0, best_col_reg[ch*8 +: 8]});
        end
        dist_sum = 18'(sq[0][16:0]) + 18'(sq[1][16:0]) + 18'(sq[2][16:0]);
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++) begin
            case (cmd.wsrc)
                WSRC_R7: wdata[ch*8 +: 8] = spread_ch(r_reg[ch*8 +: 8], err[ch], 3'd7);
                WSRC_L3: wdata[ch*8 +: 8] = spread_ch(l_reg[ch*8 +: 8], err[ch], 3'd3);
                WSRC_C5: wdata[ch*8 +: 8] = spread_ch(v_reg[ch*8 +: 8], err[ch], 3'd5);
                default: wdata[ch*8 +: 8] = v_reg[ch*8 +: 8];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pal_we) begin
            pal_mem[palette_slot] <= chan_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we) begin
            row_mem[cmd.mem_addr] <= wdata;
        end
        rdata_reg <= row_mem[cmd.mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.v_load) begin
            v_reg <= v_in;
        end
        case (cmd.cap)
            CAP_X:   x_reg <= rdata_reg;
            CAP_R:   r_reg <= rdata_reg;
            CAP_L:   l_reg <= rdata_reg;
            default: x_reg <= x_reg;
        endcase
        if (cmd.search_step && (first_reg || (dist_sum < best_d_reg))) begin
            best_d_reg   <= dist_sum;
            best_idx_reg <= cmd.pal_idx;
            best_col_reg <= pal_rd;
        end
        if (cmd.out_load) begin
            out_col_reg <= best_col_reg;
            out_idx_reg <= best_idx_reg;
            out_eoi_reg <= cmd.out_eoi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int ch = 0; ch < 3; ch++) begin
                held_reg[ch] <= '0;
            end
        end else begin
            if (cmd.search_init) begin
                first_reg <= 1'b1;
            end else if (cmd.search_step) begin
                first_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
            for (int ch = 0; ch < 3; ch++) begin
                if (cmd.held_clear) begin
                    held_reg[ch] <= '0;
                end else if (cmd.held_load) begin
                    held_reg[ch] <= err[ch];
                end
            end
        end
    end

    assign status.out_busy = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign out_chan0       = out_col_reg[7:0];
    assign out_chan1       = out_col_reg[15:8];
    assign out_chan2       = out_col_reg[23:16];
    assign palette_choice  = out_idx_reg;
    assign end_of_image    = out_eoi_reg;

endmodule

// ----- sim/palette_error_diffusion_dither_test.sv -----
// ----------------------------------------------------------------------------
// palette_error_diffusion_dither_test: self-checking bench of the ditherer
// Loads palettes, streams images of many sizes through the block and compares
// every dithered pixel with a cycle-free model of Floyd-Steinberg dithering
// kept inside the bench, under random idling on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module palette_error_diffusion_dither_test;
    import pedd_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    // Covers the tail of the longest request, and so also that of a pixel
    // that produces no result.
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [3:0] idx;
        logic       eoi;
    } dither_pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            operation;
    logic [3:0]            palette_slot;
    logic [7:0]            chan0;
    logic [7:0]            chan1;
    logic [7:0]            chan2;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            out_chan0;
    logic [7:0]            out_chan1;
    logic [7:0]            out_chan2;
    logic [3:0]            palette_choice;
    logic                  end_of_image;

    palette_error_diffusion_dither i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .palette_slot   (palette_slot),
        .chan0          (chan0),
        .chan1          (chan1),
        .chan2          (chan2),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_chan0      (out_chan0),
        .out_chan1      (out_chan1),
        .out_chan2      (out_chan2),
        .palette_choice (palette_choice),
        .end_of_image   (end_of_image)
    );

    // Dithered pixels the block still owes us, oldest first.
    dither_pixel_t pending_pixels[$];
    int            fail_count;
    int            cycle_count;
    bit            no_idle;       // when set, neither side idles
    bit            hold_off_req;  // asks the receiver for one long stall
    int            hold_off_len;

    // Shadow state of the ditherer.
    logic [7:0] pal_rgb   [PAL_DEPTH][3];
    logic [7:0] emit_row  [MAX_WIDTH][3];
    logic [7:0] recv_row  [MAX_WIDTH][3];
    int         in_col;
    int         in_row;
    int         out_col;
    int         diag_err  [3];
    int         width_reg;
    int         height_reg;
    int         count_reg;

    // Free-running clock with a 10 ns period.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL palette_error_diffusion_dither");
            $finish;
        end
    end

    function automatic int used_width();
        if (width_reg < 1) return 1;
        return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function automatic int used_height();
        if (height_reg < 1) return 1;
        return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    endfunction

    function automatic int used_count();
        if (count_reg < 1) return 1;
        return (count_reg > PAL_DEPTH) ? PAL_DEPTH : count_reg;
    endfunction

    // One diffusion step on one channel: v + e*k/16, rounded half to even,
    // then clamped to the 8-bit range.
    function automatic logic [7:0] diffuse(logic [7:0] v, int e, int k);
        int sum;
        int q;
        int frac;
        sum  = int'(v) * 16 + e * k;
        q    = sum >>> 4;
        frac = sum & 15;
        if (frac > 8 || (frac == 8 && (q & 1) != 0))
        begin
            q++;
        end
        if (q < 0) q = 0;
        if (q > 255) q = 255;
        return q[7:0];
    endfunction

    function automatic void restart_image();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        for (int ch = 0; ch < 3; ch++)
        begin
            diag_err[ch] = 0;
        end
    endfunction

    // Quantize column col of the row being emitted, spread its error and
    // queue the dithered pixel.
    function automatic void quantize_column(int col, bit has_below, bit last);
        int            best;
        int            best_dist;
        int            sq_sum;
        int            diff;
        int            err [3];
        dither_pixel_t px;
        best      = 0;
        best_dist = -1;
        for (int i = 0; i < used_count(); i++)
        begin
            sq_sum = 0;
            for (int ch = 0; ch < 3; ch++)
            begin
                diff = int'(emit_row[col][ch]) - int'(pal_rgb[i][ch]);
                sq_sum += diff * diff;
            end
            if (best_dist < 0 || sq_sum < best_dist)
            begin
                best_dist = sq_sum;
                best      = i;
            end
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            err[ch] = int'(emit_row[col][ch]) - int'(pal_rgb[best][ch]);
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            if (col + 1 < used_width())
            begin
                emit_row[col + 1][ch] = diffuse(emit_row[col + 1][ch], err[ch], 7);
            end
            if (has_below)
            begin
                if (col >= 1)
                begin
                    recv_row[col - 1][ch] = diffuse(recv_row[col - 1][ch], err[ch], 3);
                end
                recv_row[col][ch] = diffuse(recv_row[col][ch], err[ch], 5);
                if (col + 1 < used_width())
                begin
                    diag_err[ch] = err[ch];
                end
            end
            emit_row[col][ch] = pal_rgb[best][ch];
        end
        px.c0  = pal_rgb[best][0];
        px.c1  = pal_rgb[best][1];
        px.c2  = pal_rgb[best][2];
        px.idx = best[3:0];
        px.eoi = last;
        pending_pixels.insert(pending_pixels.size(), px);
    endfunction

    // Advance the shadow state by one accepted request.
    function automatic void predict_request(logic [1:0] op, logic [3:0] slot,
                                            logic [7:0] c0, logic [7:0] c1,
                                            logic [7:0] c2);
        int w;
        int h;
        w = used_width();
        h = used_height();
        case (op)
            OP_PALETTE:
            begin
                pal_rgb[slot][0] = c0;
                pal_rgb[slot][1] = c1;
                pal_rgb[slot][2] = c2;
            end
            OP_PIXEL:
            begin
                // Pixels beyond the last row are dropped while draining.
                if (in_row < h && in_col < w)
                begin
                    recv_row[in_col][0] = c0;
                    recv_row[in_col][1] = c1;
                    recv_row[in_col][2] = c2;
                    if (in_row >= 1)
                    begin
                        if (in_col >= 1)
                        begin
                            for (int ch = 0; ch < 3; ch++)
                            begin
                                recv_row[in_col][ch] =
                                    diffuse(recv_row[in_col][ch], diag_err[ch], 1);
                            end
                        end
                        quantize_column(in_col, 1'b1, 1'b0);
                        out_col = in_col + 1;
                    end
                    if (in_col + 1 >= w)
                    begin
                        emit_row = recv_row;
                        in_col   = 0;
                        in_row++;
                        out_col  = 0;
                    end
                    else
                    begin
                        in_col++;
                    end
                end
            end
            OP_DRAIN:
            begin
                // A drain only counts once the whole image has been received.
                if (in_row == h && out_col < w)
                begin
                    quantize_column(out_col, 1'b0, out_col + 1 >= w);
                    if (out_col + 1 >= w)
                    begin
                        restart_image();
                    end
                    else
                    begin
                        out_col++;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Random gap length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Channel values lean toward the extremes now and then.
    function automatic logic [7:0] pick_chan();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic send_request(logic [1:0] op, logic [3:0] slot, logic [7:0] c0,
                                logic [7:0] c1, logic [7:0] c2);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        operation    <= op;
        palette_slot <= slot;
        chan0        <= c0;
        chan1        <= c1;
        chan2        <= c2;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_request(op, slot, c0, c1, c2);
    endtask

    task automatic send_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
        send_request(OP_PIXEL, 4'd0, c0, c1, c2);
    endtask

    task automatic send_drain();
        send_request(OP_DRAIN, 4'($urandom_range(0, 15)), pick_chan(), pick_chan(),
                     pick_chan());
    endtask

    // Lower valid, wait for every owed pixel and let the block settle.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [1:0] index, int value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_WIDTH:
            begin
                width_reg = value & 16'h7FF;
                restart_image();
            end
            REG_HEIGHT:
            begin
                height_reg = value & 16'h1FFF;
                restart_image();
            end
            REG_COUNT:
            begin
                count_reg = value & 16'h1F;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic set_image(int w, int h);
        write_register(REG_WIDTH, w);
        write_register(REG_HEIGHT, h);
    endtask

    // A whole image of random pixels followed by the drains of its last row.
    task automatic run_image();
        int w;
        int h;
        w = used_width();
        h = used_height();
        for (int i = 0; i < w * h; i++)
        begin
            send_pixel(pick_chan(), pick_chan(), pick_chan());
        end
        for (int i = 0; i < w; i++)
        begin
            send_drain();
        end
    endtask

    // Load every palette entry so that no search reads an unwritten one.
    // Black and white sit at the ends, and two entries share one color so
    // that the lower index must win the tie.
    task automatic test_palette_load();
        write_register(REG_COUNT, 16);
        send_request(OP_PALETTE, 4'd0, 8'd0, 8'd0, 8'd0);
        for (int i = 1; i < 15; i++)
        begin
            send_request(OP_PALETTE, 4'(i), pick_chan(), pick_chan(), pick_chan());
        end
        send_request(OP_PALETTE, 4'd5, pal_rgb[3][0], pal_rgb[3][1], pal_rgb[3][2]);
        send_request(OP_PALETTE, 4'd15, 8'd255, 8'd255, 8'd255);
    endtask

    // A 3x2 image built from extreme values, with the ignored requests mixed in.
    task automatic test_directed_image();
        set_image(3, 2);
        send_drain();                                       // not draining yet
        send_request(OP_RESERVED, 4'd9, 8'd1, 8'd2, 8'd3);  // unknown operation
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(pal_rgb[3][0], pal_rgb[3][1], pal_rgb[3][2]);   // exact tie
        send_pixel(8'd128, 8'd127, 8'd1);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd77, 8'd77, 8'd77);                    // dropped while draining
        send_drain();
        send_drain();
        send_drain();
        send_drain();                                       // after the image ended
    endtask

    // Palette count at both ends and beyond the range it is clamped to.
    task automatic test_palette_count();
        int counts [4] = '{0, 1, 31, 16};
        set_image(4, 2);
        foreach (counts[i])
        begin
            write_register(REG_COUNT, counts[i]);
            run_image();
        end
    endtask

    // Width and height at their small extremes, including zero, which is
    // used as one, plus a single row and a single column.
    task automatic test_image_size();
        set_image(0, 0);
        run_image();
        set_image(1, 1);
        run_image();
        set_image(7, 1);
        run_image();
        set_image(1, 5);
        run_image();
    endtask

    // Rewriting the width mid-image throws away the partial image.
    task automatic test_restart();
        set_image(5, 3);
        for (int i = 0; i < 8; i++)
        begin
            send_pixel(pick_chan(), pick_chan(), pick_chan());
        end
        write_register(REG_WIDTH, 4);
        run_image();
    endtask

    // The receiver stalls for a long stretch while requests keep coming,
    // so the block backs up and stalls its input.
    task automatic test_back_pressure();
        set_image(6, 4);
        wait_idle();
        hold_off_len = 400;
        hold_off_req = 1'b1;
        no_idle      = 1'b1;
        run_image();
        no_idle      = 1'b0;
    endtask

    // Mostly well-formed random images, with palette rewrites and stray
    // requests thrown in; now and then an image runs with no idling at all.
    task automatic test_random_images();
        int sent;
        int w;
        int h;
        sent = 0;
        while (sent < 230)
        begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 4);
            set_image(w, h);
            write_register(REG_COUNT, $urandom_range(0, 20));
            no_idle = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < w * h; i++)
            begin
                case ($urandom_range(0, 19))
                    0: send_request(OP_PALETTE, 4'($urandom_range(0, 15)), pick_chan(),
                                    pick_chan(), pick_chan());
                    1: send_request(OP_RESERVED, 4'($urandom_range(0, 15)), pick_chan(),
                                    pick_chan(), pick_chan());
                    2: send_drain();
                    default:
                    begin
                    end
                endcase
                send_pixel(pick_chan(), pick_chan(), pick_chan());
            end
            if ($urandom_range(0, 3) == 0)
            begin
                send_pixel(pick_chan(), pick_chan(), pick_chan());
            end
            // Now and then the image is cut short by the next width write.
            for (int i = 0; i < w; i++)
            begin
                if ($urandom_range(0, 29) != 0)
                begin
                    send_drain();
                end
            end
            sent += w * h + w;
            no_idle = 1'b0;
        end
    endtask

    // Receiver: random stalls, mostly short, plus the long hold-off on request.
    initial
    begin
        int r;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (hold_off_len) @(negedge clk);
                hold_off_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (no_idle)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                out_stall <= (r < 20);
                if (r < 2)
                begin
                    repeat ($urandom_range(10, 40)) @(negedge clk);
                end
            end
        end
    end

    // Compare every accepted result with the oldest owed pixel.
    always @(posedge clk)
    begin
        dither_pixel_t exp_px;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected result: out_chan0 %0d palette_choice %0d",
                       out_chan0, palette_choice);
                fail_count++;
            end
            else
            begin
                exp_px = pending_pixels.pop_front();
                if (out_chan0 !== exp_px.c0)
                begin
                    $error("out_chan0: expected %0d, actual %0d", exp_px.c0, out_chan0);
                    fail_count++;
                end
                if (out_chan1 !== exp_px.c1)
                begin
                    $error("out_chan1: expected %0d, actual %0d", exp_px.c1, out_chan1);
                    fail_count++;
                end
                if (out_chan2 !== exp_px.c2)
                begin
                    $error("out_chan2: expected %0d, actual %0d", exp_px.c2, out_chan2);
                    fail_count++;
                end
                if (palette_choice !== exp_px.idx)
                begin
                    $error("palette_choice: expected %0d, actual %0d", exp_px.idx,
                           palette_choice);
                    fail_count++;
                end
                if (end_of_image !== exp_px.eoi)
                begin
                    $error("end_of_image: expected %0d, actual %0d", exp_px.eoi,
                           end_of_image);
                    fail_count++;
                end
            end
        end
    end

    // Reset, then every test in turn, then the verdict.
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_WIDTH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        operation    = OP_PALETTE;
        palette_slot = 4'd0;
        chan0        = 8'd0;
        chan1        = 8'd0;
        chan2        = 8'd0;
        fail_count   = 0;
        cycle_count  = 0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        hold_off_len = 0;
        width_reg    = 1;
        height_reg   = 1;
        count_reg    = 16;
        restart_image();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_palette_load();
        test_directed_image();
        test_palette_count();
        test_image_size();
        test_restart();
        test_back_pressure();
        test_random_images();

        wait_idle();
        repeat (100) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("PASS palette_error_diffusion_dither");
        end
        else
        begin
            $display("FAIL palette_error_diffusion_dither");
        end
        $finish;
    end

endmodule
